>>> rtl/r2q_pkg.sv
`default_nettype none
package r2q_pkg;
   localparam int DataWidth = 16;
   localparam int FracBits  = 14;
   localparam int AccWidth  = DataWidth + 3;
   localparam int SumWidth  = DataWidth + 1;
   localparam int ArgWidth  = DataWidth + 1;
   localparam int RadWidth  = 2 * ((ArgWidth + FracBits + 1) / 2);
   localparam int RootWidth = RadWidth / 2;
   localparam int RemWidth  = RootWidth + 2;
   localparam int DivWidth  = RootWidth + 1;
   localparam int QuotWidth = DataWidth + 1;
   localparam int DendWidth = SumWidth + FracBits;
   localparam int CmpWidth  = DivWidth + QuotWidth;
   localparam int Lanes     = 3;
   localparam int FifoDepth = 4;
   localparam int PtrWidth  = $clog2(FifoDepth);

   typedef enum logic [1:0] {SEL_W, SEL_X, SEL_Y, SEL_Z} sel_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] r00;
      logic signed [DataWidth-1:0] r01;
      logic signed [DataWidth-1:0] r02;
      logic signed [DataWidth-1:0] r10;
      logic signed [DataWidth-1:0] r11;
      logic signed [DataWidth-1:0] r12;
      logic signed [DataWidth-1:0] r20;
      logic signed [DataWidth-1:0] r21;
      logic signed [DataWidth-1:0] r22;
   } req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] quat_w;
      logic signed [DataWidth-1:0] quat_x;
      logic signed [DataWidth-1:0] quat_y;
      logic signed [DataWidth-1:0] quat_z;
      logic                        degenerate;
   } rsp_type;

   // classified word: major component, sqrt argument, off-diagonal numerators
   typedef struct packed {
      sel_type                          sel;
      logic [ArgWidth-1:0]              arg;
      logic [Lanes-1:0][SumWidth-1:0]   num;
   } item_type;

   typedef struct packed {
      sel_type               sel;
      logic [Lanes-1:0]      neg;
      logic [Lanes-1:0]      ovf;
      logic [RootWidth:0]    major;
      logic                  degenerate;
   } ctl_type;

   function automatic logic [DataWidth-1:0] sat_quot(input logic [QuotWidth-1:0] q,
                                                     input logic ovf, input logic neg);
      logic [QuotWidth-1:0] lim;
      logic [QuotWidth-1:0] qs;
      lim = QuotWidth'(1) << (DataWidth - 1);
      qs  = (ovf || q > lim) ? lim : q;
      if (neg)
         return DataWidth'(-qs);
      else if (qs >= lim)
         return {1'b0, {(DataWidth-1){1'b1}}};
      else
         return qs[DataWidth-1:0];
   endfunction
endpackage
`default_nettype wire

>>> rtl/r2q_front.sv
`default_nettype none
module r2q_front (
   input  wire r2q_pkg::req_type req,
   output r2q_pkg::item_type     item
);
   localparam int AW = r2q_pkg::AccWidth;
   localparam int SW = r2q_pkg::SumWidth;

   logic signed [AW-1:0] m00, m11, m22, one, trace, arg_raw;
   logic signed [SW-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;

   assign m00 = AW'(req.r00);
   assign m11 = AW'(req.r11);
   assign m22 = AW'(req.r22);
   assign one = AW'(1) <<< r2q_pkg::FracBits;
   assign trace = m00 + m11 + m22;

   assign d21_12 = SW'(req.r21) - SW'(req.r12);
   assign d02_20 = SW'(req.r02) - SW'(req.r20);
   assign d10_01 = SW'(req.r10) - SW'(req.r01);
   assign s01_10 = SW'(req.r01) + SW'(req.r10);
   assign s02_20 = SW'(req.r02) + SW'(req.r20);
   assign s12_21 = SW'(req.r12) + SW'(req.r21);

   always_comb begin
      if (trace > 0) begin
         item.sel = r2q_pkg::SEL_W;
         arg_raw  = trace + one;
         item.num = {d10_01, d02_20, d21_12};
      end else if (m00 > m11 && m00 > m22) begin
         item.sel = r2q_pkg::SEL_X;
         arg_raw  = one + m00 - m11 - m22;
         item.num = {s02_20, s01_10, d21_12};
      end else if (m11 > m22) begin
         item.sel = r2q_pkg::SEL_Y;
         arg_raw  = one + m11 - m00 - m22;
         item.num = {s12_21, s01_10, d02_20};
      end else begin
         item.sel = r2q_pkg::SEL_Z;
         arg_raw  = one + m22 - m00 - m11;
         item.num = {s12_21, s02_20, d10_01};
      end
      item.arg = arg_raw[AW-1] ? '0 : arg_raw[r2q_pkg::ArgWidth-1:0];
   end
endmodule
`default_nettype wire

>>> rtl/r2q_fifo.sv
`default_nettype none
module r2q_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire r2q_pkg::item_type push_item,
   output logic                   full,
   input  wire logic              pop,
   output logic                   empty,
   output r2q_pkg::item_type      head
);
   localparam int PW = r2q_pkg::PtrWidth;

   r2q_pkg::item_type mem_ff [r2q_pkg::FifoDepth];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   count_ff, count_in;

   assign full  = count_ff == (PW+1)'(r2q_pkg::FifoDepth);
   assign empty = count_ff == '0;
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ff] <= push_item;
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue read while empty");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");
`endif
endmodule
`default_nettype wire

>>> rtl/r2q_sqrt.sv
`default_nettype none
module r2q_sqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire r2q_pkg::item_type             in_item,
   output logic                               out_valid,
   output r2q_pkg::item_type                  out_item,
   output logic [r2q_pkg::RootWidth-1:0]      out_root
);
   localparam int N  = r2q_pkg::RootWidth;
   localparam int EW = r2q_pkg::RemWidth;
   localparam int DW = r2q_pkg::RadWidth;

   logic              valid_ff [N];
   logic [EW-1:0]     rem_ff   [N];
   logic [N-1:0]      root_ff  [N];
   logic [DW-1:0]     rad_ff   [N];
   r2q_pkg::item_type item_ff  [N];

   logic              src_valid [N];
   logic [EW-1:0]     src_rem   [N];
   logic [N-1:0]      src_root  [N];
   logic [DW-1:0]     src_rad   [N];
   r2q_pkg::item_type src_item  [N];

   logic [EW-1:0] rem_in  [N];
   logic [N-1:0]  root_in [N];
   logic [DW-1:0] rad_in  [N];

   always_comb begin
      src_valid[0] = in_valid;
      src_rem[0]   = '0;
      src_root[0]  = '0;
      src_rad[0]   = DW'({in_item.arg, {r2q_pkg::FracBits{1'b0}}});
      src_item[0]  = in_item;
      for (int k = 1; k < N; k++) begin
         src_valid[k] = valid_ff[k-1];
         src_rem[k]   = rem_ff[k-1];
         src_root[k]  = root_ff[k-1];
         src_rad[k]   = rad_ff[k-1];
         src_item[k]  = item_ff[k-1];
      end
   end

   always_comb begin
      logic [EW-1:0] t;
      logic [EW-1:0] trial;
      for (int k = 0; k < N; k++) begin
         t     = {src_rem[k][EW-3:0], src_rad[k][DW-1 -: 2]};
         trial = {src_root[k], 2'b01};
         if (t >= trial) begin
            rem_in[k]  = t - trial;
            root_in[k] = {src_root[k][N-2:0], 1'b1};
         end else begin
            rem_in[k]  = t;
            root_in[k] = {src_root[k][N-2:0], 1'b0};
         end
         rad_in[k] = src_rad[k] << 2;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         if (reset)
            valid_ff[k] <= 1'b0;
         else if (en)
            valid_ff[k] <= src_valid[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
            item_ff[k] <= src_item[k];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_item  = item_ff[N-1];
   assign out_root  = root_ff[N-1];
endmodule
`default_nettype wire

>>> rtl/r2q_div.sv
`default_nettype none
module r2q_div (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         en,
   input  wire logic                                         in_valid,
   input  wire r2q_pkg::ctl_type                             in_ctl,
   input  wire logic [r2q_pkg::DivWidth-1:0]                 in_s,
   input  wire logic [r2q_pkg::Lanes-1:0][r2q_pkg::DendWidth-1:0] in_dend,
   output logic                                              out_valid,
   output r2q_pkg::ctl_type                                  out_ctl,
   output logic [r2q_pkg::Lanes-1:0][r2q_pkg::QuotWidth-1:0] out_q
);
   localparam int N  = r2q_pkg::QuotWidth;
   localparam int SW = r2q_pkg::DivWidth;
   localparam int L  = r2q_pkg::Lanes;
   localparam int DW = r2q_pkg::DendWidth;

   logic                     valid_ff [N];
   r2q_pkg::ctl_type         ctl_ff   [N];
   logic [SW-1:0]            s_ff     [N];
   logic [L-1:0][SW-1:0]     rem_ff   [N];
   logic [L-1:0][N-1:0]      low_ff   [N];
   logic [L-1:0][N-1:0]      q_ff     [N];

   logic                     src_valid [N];
   r2q_pkg::ctl_type         src_ctl   [N];
   logic [SW-1:0]            src_s     [N];
   logic [L-1:0][SW-1:0]     src_rem   [N];
   logic [L-1:0][N-1:0]      src_low   [N];
   logic [L-1:0][N-1:0]      src_q     [N];

   logic [L-1:0][SW-1:0]     rem_in [N];
   logic [L-1:0][N-1:0]      low_in [N];
   logic [L-1:0][N-1:0]      q_in   [N];

   always_comb begin
      src_valid[0] = in_valid;
      src_ctl[0]   = in_ctl;
      src_s[0]     = in_s;
      for (int i = 0; i < L; i++) begin
         src_rem[0][i] = SW'(in_dend[i][DW-1:N]);
         src_low[0][i] = in_dend[i][N-1:0];
         src_q[0][i]   = '0;
      end
      for (int k = 1; k < N; k++) begin
         src_valid[k] = valid_ff[k-1];
         src_ctl[k]   = ctl_ff[k-1];
         src_s[k]     = s_ff[k-1];
         src_rem[k]   = rem_ff[k-1];
         src_low[k]   = low_ff[k-1];
         src_q[k]     = q_ff[k-1];
      end
   end

   always_comb begin
      logic [SW:0] t;
      logic [SW:0] d;
      for (int k = 0; k < N; k++) begin
         for (int i = 0; i < L; i++) begin
            t = {src_rem[k][i], src_low[k][i][N-1]};
            d = t - {1'b0, src_s[k]};
            if (t >= {1'b0, src_s[k]}) begin
               rem_in[k][i] = d[SW-1:0];
               q_in[k][i]   = {src_q[k][i][N-2:0], 1'b1};
            end else begin
               rem_in[k][i] = t[SW-1:0];
               q_in[k][i]   = {src_q[k][i][N-2:0], 1'b0};
            end
            low_in[k][i] = src_low[k][i] << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         if (reset)
            valid_ff[k] <= 1'b0;
         else if (en)
            valid_ff[k] <= src_valid[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            ctl_ff[k] <= src_ctl[k];
            s_ff[k]   <= src_s[k];
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            q_ff[k]   <= q_in[k];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_ctl   = ctl_ff[N-1];
   assign out_q     = q_ff[N-1];
endmodule
`default_nettype wire

>>> rtl/r2q_back.sv
`default_nettype none
module r2q_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire r2q_pkg::item_type head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output r2q_pkg::rsp_type       rsp_data
);
   localparam int L  = r2q_pkg::Lanes;
   localparam int RW = r2q_pkg::RootWidth;
   localparam int DW = r2q_pkg::DendWidth;
   localparam int QW = r2q_pkg::QuotWidth;
   localparam int OW = r2q_pkg::DataWidth;

   logic en;
   logic sq_valid;
   r2q_pkg::item_type sq_item;
   logic [RW-1:0] sq_root;

   logic prep_valid_ff;
   r2q_pkg::ctl_type prep_ctl_ff, prep_ctl_in;
   logic [r2q_pkg::DivWidth-1:0] prep_s_ff, prep_s_in;
   logic [L-1:0][DW-1:0] prep_dend_ff, prep_dend_in;

   logic dv_valid;
   r2q_pkg::ctl_type dv_ctl;
   logic [L-1:0][QW-1:0] dv_q;

   logic rsp_valid_ff;
   r2q_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign en  = !rsp_valid_ff || !rsp_stall;
   assign pop = en && head_valid;

   r2q_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (head_valid),
      .in_item   (head),
      .out_valid (sq_valid),
      .out_item  (sq_item),
      .out_root  (sq_root)
   );

   always_comb begin
      logic signed [r2q_pkg::SumWidth-1:0] n;
      logic [r2q_pkg::SumWidth-1:0] mag;
      prep_s_in               = {sq_root, 1'b0};
      prep_ctl_in.sel         = sq_item.sel;
      prep_ctl_in.major       = ((RW+1)'(sq_root) + 1'b1) >> 1;
      prep_ctl_in.degenerate  = sq_root == '0;
      for (int i = 0; i < L; i++) begin
         n = $signed(sq_item.num[i]);
         prep_ctl_in.neg[i] = n[r2q_pkg::SumWidth-1];
         mag = n[r2q_pkg::SumWidth-1] ? -n : n;
         prep_dend_in[i] = (DW'(mag) << r2q_pkg::FracBits) + DW'(sq_root);
         prep_ctl_in.ovf[i] = r2q_pkg::CmpWidth'(prep_dend_in[i]) >= {prep_s_in, {QW{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         prep_valid_ff <= 1'b0;
      else if (en)
         prep_valid_ff <= sq_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prep_ctl_ff  <= prep_ctl_in;
         prep_s_ff    <= prep_s_in;
         prep_dend_ff <= prep_dend_in;
      end
   end

   r2q_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prep_valid_ff),
      .in_ctl    (prep_ctl_ff),
      .in_s      (prep_s_ff),
      .in_dend   (prep_dend_ff),
      .out_valid (dv_valid),
      .out_ctl   (dv_ctl),
      .out_q     (dv_q)
   );

   always_comb begin
      logic [3:0][OW-1:0] comp;
      logic [L-1:0][OW-1:0] lane;
      logic [OW-1:0] major;
      logic [RW:0] sat_max;
      sat_max = (RW+1)'({1'b0, {(OW-1){1'b1}}});
      major = (dv_ctl.major > sat_max) ? {1'b0, {(OW-1){1'b1}}} : OW'(dv_ctl.major);
      for (int i = 0; i < L; i++)
         lane[i] = r2q_pkg::sat_quot(dv_q[i], dv_ctl.ovf[i], dv_ctl.neg[i]);
      unique case (dv_ctl.sel)
         r2q_pkg::SEL_W: comp = {lane[2], lane[1], lane[0], major};
         r2q_pkg::SEL_X: comp = {lane[2], lane[1], major, lane[0]};
         r2q_pkg::SEL_Y: comp = {lane[2], major, lane[1], lane[0]};
         default:        comp = {major, lane[2], lane[1], lane[0]};
      endcase
      if (dv_ctl.degenerate) begin
         rsp_data_in = '0;
         rsp_data_in.degenerate = 1'b1;
      end else begin
         rsp_data_in.quat_w     = comp[0];
         rsp_data_in.quat_x     = comp[1];
         rsp_data_in.quat_y     = comp[2];
         rsp_data_in.quat_z     = comp[3];
         rsp_data_in.degenerate = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (en)
         rsp_valid_ff <= dv_valid;
   end

   always_ff @(posedge clock) begin
      if (en)
         rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule
`default_nettype wire

>>> rtl/rotation_matrix_to_quaternion_top.sv
// Throughput: one word per cycle while rsp_stall is low; 16 square-root stages, 17 divider stages.
// A four-word queue separates the classifying front from the arithmetic back.
// Reset (synchronous) empties the queue and clears all pipeline valid bits.
`default_nettype none
module rotation_matrix_to_quaternion_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire r2q_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output r2q_pkg::rsp_type      rsp_data
);
   r2q_pkg::item_type item, head;
   logic full, empty, pop;

   r2q_front u_front (
      .req  (req_data),
      .item (item)
   );

   assign req_stall = full;

   r2q_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !full),
      .push_item (item),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   r2q_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!empty),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );
endmodule
`default_nettype wire
